// ----- rtl/core/krsp_pkg.sv -----
// Shared types and character constants for the keyed record stream parser.
package krsp_pkg;

    localparam int LEN_W = 31;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // A further digit is refused once the running value exceeds this.
    localparam logic [LEN_W-1:0] ACC_LIMIT = 31'd214748363;

    typedef enum logic [2:0] {
        KIND_START  = 3'd0,
        KIND_KEY    = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_END    = 3'd3,
        KIND_IN_END = 3'd4,
        KIND_ERROR  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       stream_end;
    } byte_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_byte;
        logic [LEN_W-1:0] key_length;
        logic [LEN_W-1:0] data_length;
        logic             last_of_field;
    } event_item_t;

    // Result of one parser step: whether an event is produced, and the event.
    typedef struct packed {
        logic        valid;
        event_item_t item;
    } step_result_t;

endpackage

// ----- rtl/core/krsp_byte_if.sv -----
// Valid/ready channel that carries one stream byte per transfer.
interface krsp_byte_if;
    logic                  valid;
    logic                  ready;
    krsp_pkg::byte_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/krsp_event_if.sv -----
// Valid/ready channel that carries one parser event per transfer.
interface krsp_event_if;
    logic                  valid;
    logic                  ready;
    krsp_pkg::event_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/krsp_parser.sv -----
// Parse state machine: consumes one registered byte per step and forms the event.
module krsp_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  krsp_pkg::byte_item_t    item,
    output krsp_pkg::step_result_t  result
);

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_KLEN  = 4'd1,
        PH_DLEN  = 4'd2,
        PH_KEY   = 4'd3,
        PH_DASH  = 4'd4,
        PH_GT    = 4'd5,
        PH_DATA  = 4'd6,
        PH_NL    = 4'd7,
        PH_HALT  = 4'd8
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [krsp_pkg::LEN_W-1:0]  key_len_reg, key_len_next;
    logic [krsp_pkg::LEN_W-1:0]  data_len_reg, data_len_next;
    logic [krsp_pkg::LEN_W-1:0]  left_reg, left_next;
    logic                        digit_seen_reg, digit_seen_next;

    logic                        is_digit;
    logic [3:0]                  digit;
    logic [7:0]                  digit_wide;
    logic [krsp_pkg::LEN_W-1:0]  acc_sel;
    logic [krsp_pkg::LEN_W+2:0]  acc_times_ten;
    logic [krsp_pkg::LEN_W-1:0]  acc_new;
    logic                        acc_over;
    logic [krsp_pkg::LEN_W-1:0]  left_dec;
    logic                        left_last;

    assign is_digit   = (item.byte_in >= krsp_pkg::CHAR_ZERO) &&
                        (item.byte_in <= krsp_pkg::CHAR_NINE);
    assign digit_wide = item.byte_in - krsp_pkg::CHAR_ZERO;
    assign digit      = digit_wide[3:0];

    // One shared multiply-by-ten: key length while in the key length, else data.
    assign acc_sel       = (phase_reg == PH_KLEN) ? key_len_reg : data_len_reg;
    assign acc_times_ten = {acc_sel, 3'b000} + {2'b00, acc_sel, 1'b0}
                         + {{(krsp_pkg::LEN_W - 1){1'b0}}, digit};
    assign acc_new       = acc_times_ten[krsp_pkg::LEN_W-1:0];
    assign acc_over      = acc_sel > krsp_pkg::ACC_LIMIT;

    assign left_dec  = left_reg - {{(krsp_pkg::LEN_W - 1){1'b0}}, 1'b1};
    assign left_last = (left_dec == '0);

    always_comb
    begin
        phase_next      = phase_reg;
        key_len_next    = key_len_reg;
        data_len_next   = data_len_reg;
        left_next       = left_reg;
        digit_seen_next = digit_seen_reg;
        result          = '0;

        if (phase_reg != PH_HALT)
        begin
            if (item.stream_end)
            begin
                phase_next        = PH_HALT;
                result.valid      = 1'b1;
                result.item.kind  = krsp_pkg::KIND_ERROR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (item.byte_in == krsp_pkg::CHAR_NL)
                        begin
                            phase_next       = PH_HALT;
                            result.valid     = 1'b1;
                            result.item.kind = krsp_pkg::KIND_IN_END;
                        end
                        else if (item.byte_in == krsp_pkg::CHAR_PLUS)
                        begin
                            key_len_next    = '0;
                            data_len_next   = '0;
                            digit_seen_next = 1'b0;
                            phase_next      = PH_KLEN;
                        end
                        else
                        begin
                            phase_next       = PH_HALT;
                            result.valid     = 1'b1;
                            result.item.kind = krsp_pkg::KIND_ERROR;
                        end
                    end
                    PH_KLEN, PH_DLEN:
                    begin
                        if (is_digit && !acc_over)
                        begin
                            digit_seen_next = 1'b1;
                            if (phase_reg == PH_KLEN)
                                key_len_next = acc_new;
                            else
                                data_len_next = acc_new;
                        end
                        else if (!is_digit && digit_seen_reg && phase_reg == PH_KLEN &&
                                 item.byte_in == krsp_pkg::CHAR_COMMA)
                        begin
                            digit_seen_next = 1'b0;
                            phase_next      = PH_DLEN;
                        end
                        else if (!is_digit && digit_seen_reg && phase_reg == PH_DLEN &&
                                 item.byte_in == krsp_pkg::CHAR_COLON)
                        begin
                            digit_seen_next         = 1'b0;
                            left_next               = key_len_reg;
                            phase_next              = (key_len_reg != '0) ? PH_KEY : PH_DASH;
                            result.valid            = 1'b1;
                            result.item.kind        = krsp_pkg::KIND_START;
                            result.item.key_length  = key_len_reg;
                            result.item.data_length = data_len_reg;
                        end
                        else
                        begin
                            phase_next       = PH_HALT;
                            result.valid     = 1'b1;
                            result.item.kind = krsp_pkg::KIND_ERROR;
                        end
                    end
                    PH_KEY, PH_DATA:
                    begin
                        left_next                 = left_dec;
                        result.valid              = 1'b1;
                        result.item.kind          = (phase_reg == PH_KEY) ?
                                                    krsp_pkg::KIND_KEY : krsp_pkg::KIND_DATA;
                        result.item.out_byte      = item.byte_in;
                        result.item.last_of_field = left_last;
                        if (left_last)
                            phase_next = (phase_reg == PH_KEY) ? PH_DASH : PH_NL;
                    end
                    PH_DASH:
                    begin
                        if (item.byte_in == krsp_pkg::CHAR_DASH)
                            phase_next = PH_GT;
                        else
                        begin
                            phase_next       = PH_HALT;
                            result.valid     = 1'b1;
                            result.item.kind = krsp_pkg::KIND_ERROR;
                        end
                    end
                    PH_GT:
                    begin
                        if (item.byte_in == krsp_pkg::CHAR_GT)
                        begin
                            left_next  = data_len_reg;
                            phase_next = (data_len_reg != '0) ? PH_DATA : PH_NL;
                        end
                        else
                        begin
                            phase_next       = PH_HALT;
                            result.valid     = 1'b1;
                            result.item.kind = krsp_pkg::KIND_ERROR;
                        end
                    end
                    PH_NL:
                    begin
                        phase_next   = (item.byte_in == krsp_pkg::CHAR_NL) ? PH_START : PH_HALT;
                        result.valid = 1'b1;
                        result.item.kind = (item.byte_in == krsp_pkg::CHAR_NL) ?
                                           krsp_pkg::KIND_END : krsp_pkg::KIND_ERROR;
                    end
                    default:
                    begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            key_len_reg    <= '0;
            data_len_reg   <= '0;
            left_reg       <= '0;
            digit_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            key_len_reg    <= key_len_next;
            data_len_reg   <= data_len_next;
            left_reg       <= left_next;
            digit_seen_reg <= digit_seen_next;
        end
    end

endmodule

// ----- rtl/core/keyed_record_stream_parser_core.sv -----
// Top level of the keyed record stream parser: input register, parser, event register.
//
// The block reads a text stream of records "+klen,dlen:key->data\n", one byte per
// transfer on byte_stream, and ends the stream on a bare newline. For each record it
// sends a record start event carrying both decimal lengths when the colon arrives,
// then one event per key byte and per data byte, with last_of_field set on the final
// byte of each field, and a record end event on the closing newline. The bare newline
// gives an input end event. Missing digits, a length that grows past 2147483639, a
// wrong separator, or a stream_end transfer anywhere give one format error event.
// After the input end or a format error the block keeps taking bytes but sends no
// more events until reset. Plus, comma, dash, '>' and digit bytes give no event.
// Throughput is one byte per clock cycle while the receiver keeps up: every transfer
// passes through an input register, the parse logic that updates the state machine,
// and an event register. An event is offered on record_events once the parse logic
// has loaded it from the input register into the event register. The parser steps
// whenever the event register is empty or is emptied in the same cycle, so back to
// back transfers flow with no gap while the receiver keeps up. When a stalled receiver
// holds an event in the event register, the input register still takes one more byte,
// and then byte_stream.ready stays low until that event transfers.
module keyed_record_stream_parser_core
(
    input  logic          clk,
    input  logic          rst_n,
    krsp_byte_if.sink     byte_stream,
    krsp_event_if.source  record_events
);

    logic                    in_valid_reg;
    krsp_pkg::byte_item_t    in_item_reg;
    logic                    out_valid_reg;
    krsp_pkg::event_item_t   out_item_reg;

    logic                    advance;
    logic                    in_take;
    krsp_pkg::step_result_t  result;

    // The parser steps when a byte is held and the event register can take its event.
    assign advance = in_valid_reg && (!out_valid_reg || record_events.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_take = byte_stream.valid && byte_stream.ready;

    krsp_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_stream.ready)
                in_valid_reg <= byte_stream.valid;

            if (advance)
                out_valid_reg <= result.valid;
            else if (record_events.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= byte_stream.data;
        if (advance && result.valid)
            out_item_reg <= result.item;
    end

    assign record_events.valid = out_valid_reg;
    assign record_events.data  = out_item_reg;

endmodule

// ----- tb/krsp_event_checker.sv -----
// Checker for the keyed record stream parser: predicts events from byte transfers and compares.
`timescale 1ns / 100ps

module krsp_event_checker
(
    input  logic  clk,
    input  logic  rst_n,
    krsp_byte_if  byte_mon,
    krsp_event_if event_mon,
    output int    check_errors,
    output int    events_pending
);
    import krsp_pkg::*;

    typedef enum logic [3:0] {
        P_OPEN,
        P_KEY_LEN,
        P_DATA_LEN,
        P_KEY_BYTES,
        P_DASH,
        P_ARROW,
        P_DATA_BYTES,
        P_NEWLINE,
        P_HALTED
    } parse_phase_t;

    parse_phase_t     phase;
    logic [LEN_W-1:0] key_len_sum;
    logic [LEN_W-1:0] data_len_sum;
    logic [LEN_W-1:0] field_left;
    logic             have_digit;
    event_item_t      expected_events[$];

    function automatic event_item_t make_event(kind_t k, logic [7:0] b, logic [LEN_W-1:0] kl,
                                               logic [LEN_W-1:0] dl, logic is_last);
        event_item_t ev;
        ev.kind          = k;
        ev.out_byte      = b;
        ev.key_length    = kl;
        ev.data_length   = dl;
        ev.last_of_field = is_last;
        return ev;
    endfunction

    task automatic raise_format_error();
        phase = P_HALTED;
        expected_events.push_back(make_event(KIND_ERROR, 8'h00, '0, '0, 1'b0));
    endtask

    task automatic take_digit(inout logic [LEN_W-1:0] acc, input logic [LEN_W-1:0] digit);
        if (acc > ACC_LIMIT)
        begin
            raise_format_error();
        end
        else
        begin
            acc        = acc * 31'd10 + digit;
            have_digit = 1'b1;
        end
    endtask

    task automatic parse_byte(input byte_item_t item);
        logic [7:0]       c;
        logic             is_digit;
        logic [LEN_W-1:0] digit;
        logic             is_last;
        c        = item.byte_in;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        digit    = LEN_W'(c - CHAR_ZERO);
        if (phase == P_HALTED)
            return;
        if (item.stream_end)
        begin
            raise_format_error();
            return;
        end
        case (phase)
            P_OPEN:
            begin
                if (c == CHAR_NL)
                begin
                    phase = P_HALTED;
                    expected_events.push_back(make_event(KIND_IN_END, 8'h00, '0, '0, 1'b0));
                end
                else if (c != CHAR_PLUS)
                    raise_format_error();
                else
                begin
                    key_len_sum  = '0;
                    data_len_sum = '0;
                    have_digit   = 1'b0;
                    phase        = P_KEY_LEN;
                end
            end
            P_KEY_LEN:
            begin
                if (is_digit)
                    take_digit(key_len_sum, digit);
                else if (c != CHAR_COMMA || !have_digit)
                    raise_format_error();
                else
                begin
                    have_digit = 1'b0;
                    phase      = P_DATA_LEN;
                end
            end
            P_DATA_LEN:
            begin
                if (is_digit)
                    take_digit(data_len_sum, digit);
                else if (c != CHAR_COLON || !have_digit)
                    raise_format_error();
                else
                begin
                    have_digit = 1'b0;
                    field_left = key_len_sum;
                    phase      = (key_len_sum != '0) ? P_KEY_BYTES : P_DASH;
                    expected_events.push_back(make_event(KIND_START, 8'h00, key_len_sum,
                                                         data_len_sum, 1'b0));
                end
            end
            P_KEY_BYTES:
            begin
                field_left = field_left - 31'd1;
                is_last    = (field_left == '0);
                if (is_last)
                    phase = P_DASH;
                expected_events.push_back(make_event(KIND_KEY, c, '0, '0, is_last));
            end
            P_DASH:
            begin
                if (c != CHAR_DASH)
                    raise_format_error();
                else
                    phase = P_ARROW;
            end
            P_ARROW:
            begin
                if (c != CHAR_GT)
                    raise_format_error();
                else
                begin
                    field_left = data_len_sum;
                    phase      = (data_len_sum != '0) ? P_DATA_BYTES : P_NEWLINE;
                end
            end
            P_DATA_BYTES:
            begin
                field_left = field_left - 31'd1;
                is_last    = (field_left == '0);
                if (is_last)
                    phase = P_NEWLINE;
                expected_events.push_back(make_event(KIND_DATA, c, '0, '0, is_last));
            end
            P_NEWLINE:
            begin
                if (c != CHAR_NL)
                    raise_format_error();
                else
                begin
                    phase = P_OPEN;
                    expected_events.push_back(make_event(KIND_END, 8'h00, '0, '0, 1'b0));
                end
            end
            default:
                phase = P_HALTED;
        endcase
    endtask

    task automatic compare_event(input event_item_t want, input event_item_t got);
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            check_errors++;
        end
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
            check_errors++;
        end
        if (got.key_length !== want.key_length)
        begin
            $error("key_length: expected %0d, actual %0d", want.key_length, got.key_length);
            check_errors++;
        end
        if (got.data_length !== want.data_length)
        begin
            $error("data_length: expected %0d, actual %0d", want.data_length, got.data_length);
            check_errors++;
        end
        if (got.last_of_field !== want.last_of_field)
        begin
            $error("last_of_field: expected %0d, actual %0d", want.last_of_field,
                   got.last_of_field);
            check_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        event_item_t want;
        if (!rst_n)
        begin
            phase        = P_OPEN;
            key_len_sum  = '0;
            data_len_sum = '0;
            field_left   = '0;
            have_digit   = 1'b0;
            expected_events.delete();
            check_errors   = 0;
            events_pending = 0;
        end
        else
        begin
            // Events are compared before this edge's byte is predicted; the block's input and
            // event registers keep the two apart anyway.
            if (event_mon.valid && event_mon.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("kind: expected none, actual %0d", event_mon.data.kind);
                    check_errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    compare_event(want, event_mon.data);
                end
            end
            if (byte_mon.valid && byte_mon.ready)
                parse_byte(byte_mon.data);
            events_pending = expected_events.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the keyed record stream parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import krsp_pkg::*;

    // This bound only catches a hung handshake.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the long receiver stall that backs the block up into its input.
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_BYTES = 420;

    logic clk;
    logic rst_n;
    int   check_errors;
    int   events_pending;
    int   cycle_count;
    int   bytes_sent;

    // While calm is set neither side idles; hold_request asks the receiver for a long stall.
    bit   calm;
    bit   hold_request;

    // Bytes of the record being built, sent in full or cut short.
    logic [7:0] record_bytes[$];

    krsp_byte_if  byte_stream();
    krsp_event_if record_events();

    keyed_record_stream_parser_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_stream),
        .record_events (record_events)
    );

    krsp_event_checker u_event_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_mon       (byte_stream),
        .event_mon      (record_events),
        .check_errors   (check_errors),
        .events_pending (events_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a run that never drains ends here as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Receiver: ready is dropped at random, except in the calm stretch, and held low
    // for a long stall when the stimulus asks for one. The stall is counted here so the
    // sender keeps offering bytes while it lasts.
    initial
    begin
        record_events.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                record_events.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                record_events.ready <= calm || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // Offers one byte and returns at the edge that completes its transfer. Idle cycles
    // go in front of the byte, so valid is never lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic is_end);
        byte_item_t item;
        item.byte_in    = b;
        item.stream_end = is_end;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                byte_stream.valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_stream.valid <= 1'b1;
        byte_stream.data  <= item;
        @(posedge clk);
        while (!byte_stream.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_first(input int count);
        for (int i = 0; i < count; i++)
            send_byte(record_bytes[i], 1'b0);
    endtask

    // The sender stops offering until every predicted event has come out.
    task automatic wait_drained();
        byte_stream.valid <= 1'b0;
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
    endtask

    // Field content leans toward the characters that mean something to the parser,
    // so that they also show up as plain key and data bytes.
    function automatic logic [7:0] rand_octet();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return CHAR_NL;
            1: return CHAR_PLUS;
            2: return CHAR_COMMA;
            3: return CHAR_COLON;
            4: return CHAR_DASH;
            5: return CHAR_GT;
            6: return CHAR_ZERO;
            default: return CHAR_NINE;
        endcase
    endfunction

    // A byte that is neither the expected one, a newline nor a digit, so that it
    // is a wrong separator in every phase that it is used for.
    function automatic logic [7:0] wrong_octet(input logic [7:0] good);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == good || b == CHAR_NL || b == CHAR_PLUS || (b >= CHAR_ZERO && b <= CHAR_NINE));
        return b;
    endfunction

    // Mostly short fields, some empty, a few longer ones.
    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0: return 0;
            8: return $urandom_range(7, 40);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic push_decimal(input int unsigned n);
        string s;
        // A leading zero now and then leaves the value unchanged.
        if ($urandom_range(0, 7) == 0)
            record_bytes.push_back(CHAR_ZERO);
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++)
            record_bytes.push_back(s[i]);
    endtask

    task automatic build_record(input int klen, input int dlen);
        record_bytes.delete();
        record_bytes.push_back(CHAR_PLUS);
        push_decimal(klen);
        record_bytes.push_back(CHAR_COMMA);
        push_decimal(dlen);
        record_bytes.push_back(CHAR_COLON);
        for (int i = 0; i < klen; i++)
            record_bytes.push_back(rand_octet());
        record_bytes.push_back(CHAR_DASH);
        record_bytes.push_back(CHAR_GT);
        for (int i = 0; i < dlen; i++)
            record_bytes.push_back(rand_octet());
        record_bytes.push_back(CHAR_NL);
    endtask

    initial
    begin
        int record_count;
        int klen;
        int dlen;
        calm         = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        byte_stream.valid <= 1'b0;
        byte_stream.data  <= '0;
        rst_n             <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed records: both fields empty, then the extreme byte values as
        // content, including a newline as the final data byte, and a leading zero.
        send_text("+0,0:->\n");
        send_text("+01,2:");
        send_byte(8'h00, 1'b0);
        send_text("->");
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_NL, 1'b0);
        send_byte(CHAR_NL, 1'b0);

        // Well-formed records with random lengths and content. Only one stream can be
        // parsed per reset, so every malformed case waits for the very end.
        record_count = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            calm = (record_count >= 4 && record_count < 10);
            if (record_count == 12)
            begin
                // Long key while the receiver stalls: the block fills and stops
                // taking bytes until ready comes back.
                hold_request = 1'b1;
                build_record(24, 8);
            end
            else
            begin
                build_record(pick_len(), pick_len());
            end
            send_first(record_bytes.size());
            if (record_count == 16)
                wait_drained();
            record_count++;
        end
        calm = 1'b0;

        // The stream ends in one of its possible ways, picked at random.
        case ($urandom_range(0, 6))
            0:
            begin
                // Bare newline: the proper input end.
                send_byte(CHAR_NL, 1'b0);
            end
            1:
            begin
                // Stream end where a record should start.
                send_byte(rand_octet(), 1'b1);
            end
            2:
            begin
                // Stream end somewhere inside a record.
                build_record(pick_len() + 1, pick_len());
                send_first($urandom_range(1, record_bytes.size() - 1));
                send_byte(rand_octet(), 1'b1);
            end
            3:
            begin
                // A separator before any digit of its number.
                if ($urandom_range(0, 1) == 0)
                    send_text("+,");
                else
                    send_text("+12,:");
            end
            4:
            begin
                // A digit arriving after the running value has passed the limit.
                if ($urandom_range(0, 1) == 0)
                    send_text("+2147483640");
                else
                    send_text("+5,2147483649");
            end
            5:
            begin
                // A wrong byte where a fixed character belongs.
                klen = pick_len();
                dlen = pick_len();
                build_record(klen, dlen);
                case ($urandom_range(0, 3))
                    0: send_byte(wrong_octet(CHAR_PLUS), 1'b0);
                    1:
                    begin
                        send_text("+3");
                        send_byte(wrong_octet(CHAR_COMMA), 1'b0);
                    end
                    2:
                    begin
                        send_first(record_bytes.size() - dlen - 3);
                        send_byte(wrong_octet(CHAR_DASH), 1'b0);
                    end
                    default:
                    begin
                        send_first(record_bytes.size() - 1);
                        send_byte(wrong_octet(CHAR_NL), 1'b0);
                    end
                endcase
            end
            default:
            begin
                // The largest lengths that parse, cut off by a stream end in the key.
                send_text("+2147483639,2147483639:");
                repeat ($urandom_range(1, 5))
                    send_byte(rand_octet(), 1'b0);
                send_byte(rand_octet(), 1'b1);
            end
        endcase

        // The block is halted now: these transfers must give no events.
        send_byte(rand_octet(), 1'b1);
        repeat (7)
            send_byte(rand_octet(), 1'(($urandom_range(0, 1))));

        wait_drained();
        repeat (16) @(posedge clk);
        if (check_errors == 0 && events_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
